// File: src/rdba_pkg.sv
package rdba_pkg;

  localparam int REQ_W      = 2;
  localparam int PT_W       = 12;
  localparam int SAMPLE_W   = 16;
  localparam int SLOT_W     = 2;
  localparam int ACC_W      = 40;
  localparam int TW_W       = 17;
  localparam int ROM_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int ACT_W      = 3;
  localparam int PPS_W      = 13;
  localparam int CNT_W      = 12;
  localparam int NUM_STEPS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_ACCUM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FREQS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_3    = 3'd5;

  localparam logic [ACT_W-1:0] ACT_RESET = 3'd1;
  localparam logic [PPS_W-1:0] PPS_MAX   = 13'd4096;
  localparam logic [PPS_W-1:0] PPS_RESET = 13'd4096;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [TW_W-1:0] cos_tw;
    logic signed [TW_W-1:0] nsin_tw;
  } tw_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] im;
    logic signed [ACC_W-1:0] re;
  } acc_pair_t;

endpackage

// File: src/rdba_ram.sv
module rdba_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rdba_twiddle.sv
module rdba_twiddle import rdba_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic [PHASE_W-1:0] phase_i,
  output tw_t                tw_o
);

  localparam int D    = SINE_TABLE_DEPTH;
  localparam int IW   = $clog2(4 * D);
  localparam int MW   = $clog2(4 * D + 1);
  localparam int RW   = $clog2(D + 1);
  localparam int PW   = PHASE_W + MW;

  typedef logic [ROM_W-1:0] rom_t [0:D];

  function automatic longint unsigned udiv(
    input longint unsigned num,
    input longint unsigned den
  );
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    rom_t              t;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            v;
    for (int k = 0; k <= D; k++) begin
      x    = udiv(HALF_PI_Q30 * longint'(k), longint'(D));
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = udiv((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32768 + (longint'(1) << 29)) >> 30;
      if (v > 32768) begin
        v = 32768;
      end
      t[k] = ROM_W'(v);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  localparam logic [MW-1:0] FOUR_D = MW'(4 * D);
  localparam logic [IW-1:0] D1     = IW'(D);
  localparam logic [IW-1:0] D2     = IW'(2 * D);
  localparam logic [IW-1:0] D3     = IW'(3 * D);
  localparam logic [RW-1:0] DR     = RW'(D);

  logic [PW-1:0]    prod;
  logic [IW-1:0]    idx_d, idx_q;
  logic [1:0]       quad;
  logic [IW-1:0]    base;
  logic [RW-1:0]    r, rr;
  logic [RW-1:0]    caddr_d, caddr_q, saddr_d, saddr_q;
  logic             cneg_q, sneg_q, cneg2_q, sneg2_q;
  logic [ROM_W-1:0] cmag_q, smag_q;
  logic [TW_W-1:0]  cmag_x, smag_x;

  assign prod  = PW'(phase_i) * PW'(FOUR_D);
  assign idx_d = prod[PHASE_W +: IW];

  always_comb begin
    if (idx_q >= D3) begin
      quad = 2'd3;
      base = D3;
    end else if (idx_q >= D2) begin
      quad = 2'd2;
      base = D2;
    end else if (idx_q >= D1) begin
      quad = 2'd1;
      base = D1;
    end else begin
      quad = 2'd0;
      base = '0;
    end
    r       = RW'(idx_q - base);
    rr      = DR - r;
    caddr_d = quad[0] ? r : rr;
    saddr_d = quad[0] ? rr : r;
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    caddr_q <= caddr_d;
    saddr_q <= saddr_d;
    cneg_q  <= quad[0] ^ quad[1];
    sneg_q  <= ~quad[1];
    cmag_q  <= SINE_ROM[caddr_q];
    smag_q  <= SINE_ROM[saddr_q];
    cneg2_q <= cneg_q;
    sneg2_q <= sneg_q;
  end

  assign cmag_x = {1'b0, cmag_q};
  assign smag_x = {1'b0, smag_q};

  assign tw_o.cos_tw  = cneg2_q ? -cmag_x : cmag_x;
  assign tw_o.nsin_tw = sneg2_q ? -smag_x : smag_x;

endmodule

// File: src/rdba_mac.sv
module rdba_mac import rdba_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  tw_t                        tw_i,
  input  acc_pair_t                  acc_i,
  output acc_pair_t                  acc_o
);

  localparam int PROD_W = SAMPLE_W + TW_W;

  logic signed [PROD_W-1:0] prod_re_d, prod_re_q;
  logic signed [PROD_W-1:0] prod_im_d, prod_im_q;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + (ACC_W+1)'(p);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  assign prod_re_d = PROD_W'(sample_i) * PROD_W'($signed(tw_i.cos_tw));
  assign prod_im_d = PROD_W'(sample_i) * PROD_W'($signed(tw_i.nsin_tw));

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
  end

  assign acc_o.re = sat_add(acc_i.re, prod_re_q);
  assign acc_o.im = sat_add(acc_i.im, prod_im_q);

endmodule

// File: src/running_dft_bin_accumulator.sv
// Channel   Handshake              Payload
// request   start, busy            req_type_i, point_index_i, sample_value_i, freq_slot_i
// result    valid_o (one cycle)    real_sum_o, imag_sum_o
// config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Accumulate: one of the act active slots enters the twiddle/multiply/read-modify-write
// pipeline per cycle, busy until it drains; with no slot touched only the counter steps.
// Read: the request enters ST_READ, and the valid_o strobe is registered from that state.
// Clear and reset: a sweep of the accumulator memory, one entry per cycle
// (MAX_FREQS rounded up to a power of two, times GRID_POINTS rounded up, 16384 by default).
// Results cannot be held off; config writes are taken at any time.
module running_dft_bin_accumulator import rdba_pkg::*; #(
  parameter int MAX_FREQS        = 4,
  parameter int GRID_POINTS      = 4096,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic [PT_W-1:0]            point_index_i,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic [SLOT_W-1:0]          freq_slot_i,
  output logic                       valid_o,
  output logic signed [ACC_W-1:0]    real_sum_o,
  output logic signed [ACC_W-1:0]    imag_sum_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int SLOT_AW   = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
  localparam int PT_AW     = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int AW        = SLOT_AW + PT_AW;
  localparam int DEPTH     = 1 << AW;
  localparam int MAXF_CAP  = (MAX_FREQS > 7) ? 7 : MAX_FREQS;
  localparam int CW        = (SLOT_AW > ACT_W) ? SLOT_AW : ACT_W;
  localparam int ACC_PAIR_W = $bits(acc_pair_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_e;

  state_e                     state_d, state_q;
  logic [SLOT_AW-1:0]         slot_d, slot_q;
  logic [AW-1:0]              clr_d, clr_q;
  logic [CNT_W-1:0]           cnt_d, cnt_q, cnt_inc;

  logic [ACT_W-1:0]           active_q;
  logic [PPS_W-1:0]           pps_q;
  logic [PHASE_W-1:0]         phase_step_q [NUM_STEPS];
  logic [PHASE_W-1:0]         phase_q [MAX_FREQS];

  logic [PT_AW-1:0]           pt_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       rzero_q;

  logic [4:1]                 pv_q;
  logic [AW-1:0]              pa_q [1:4];

  logic                       accept;
  logic                       in_grid;
  logic                       slot_ok;
  logic [ACT_W-1:0]           act;
  logic                       do_slots;
  logic                       last_slot;
  logic                       advance;
  logic                       clr_all;
  logic [PPS_W-1:0]           lim;
  logic                       wrap;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ACC_PAIR_W-1:0]      ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ACC_PAIR_W-1:0]      ram_rdata;
  acc_pair_t                  ram_pair;
  acc_pair_t                  mac_sum;
  tw_t                        tw;

  logic                       valid_q;
  logic signed [ACC_W-1:0]    real_sum_q, imag_sum_q;

  assign busy     = (state_q != ST_IDLE) || (|pv_q);
  assign accept   = start && !busy;
  assign in_grid  = 32'(point_index_i) < 32'(GRID_POINTS);
  assign slot_ok  = 32'(freq_slot_i) < 32'(MAX_FREQS);
  assign act      = (active_q > ACT_W'(MAXF_CAP)) ? ACT_W'(MAXF_CAP) : active_q;
  assign do_slots = in_grid && (act != '0);
  assign last_slot = (CW'(slot_q) + CW'(1)) == CW'(act);

  assign advance = (accept && (req_type_i == REQ_ACCUM) && !do_slots) ||
                   ((state_q == ST_ISSUE) && last_slot);
  assign clr_all = accept && (req_type_i == REQ_CLEAR);

  always_comb begin
    if (pps_q == '0) begin
      lim = PPS_W'(1);
    end else if (pps_q > PPS_MAX) begin
      lim = PPS_MAX;
    end else begin
      lim = pps_q;
    end
    cnt_inc = cnt_q + CNT_W'(1);
    wrap    = (cnt_inc == '0) || ({1'b0, cnt_inc} >= lim);
    if (clr_all) begin
      cnt_d = '0;
    end else if (advance) begin
      cnt_d = wrap ? '0 : cnt_inc;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    clr_d   = clr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_ACCUM && do_slots) begin
            state_d = ST_ISSUE;
            slot_d  = '0;
          end else if (req_type_i == REQ_READ) begin
            state_d = ST_READ;
          end else if (req_type_i == REQ_CLEAR) begin
            state_d = ST_CLEAR;
            clr_d   = '0;
          end
        end
      end
      ST_ISSUE: begin
        slot_d = slot_q + SLOT_AW'(1);
        if (last_slot) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      slot_q  <= '0;
      clr_q   <= '0;
      cnt_q   <= '0;
      pv_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      pv_q    <= {pv_q[3:1], state_q == ST_ISSUE};
      valid_q <= state_q == ST_READ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_RESET;
      pps_q    <= PPS_RESET;
      for (int i = 0; i < NUM_STEPS; i++) begin
        phase_step_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_FREQS:    active_q        <= cfg_wdata_i[ACT_W-1:0];
        CFG_POINTS_PER_STEP: pps_q           <= cfg_wdata_i[PPS_W-1:0];
        CFG_PHASE_STEP_0:    phase_step_q[0] <= cfg_wdata_i[PHASE_W-1:0];
        CFG_PHASE_STEP_1:    phase_step_q[1] <= cfg_wdata_i[PHASE_W-1:0];
        CFG_PHASE_STEP_2:    phase_step_q[2] <= cfg_wdata_i[PHASE_W-1:0];
        CFG_PHASE_STEP_3:    phase_step_q[3] <= cfg_wdata_i[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar s = 0; s < MAX_FREQS; s++) begin : g_phase
    logic [PHASE_W-1:0] step;
    if (s < NUM_STEPS) begin : g_step
      assign step = phase_step_q[s];
    end else begin : g_nostep
      assign step = '0;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[s] <= '0;
      end else if (clr_all) begin
        phase_q[s] <= '0;
      end else if (advance && wrap) begin
        phase_q[s] <= phase_q[s] + step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q     <= PT_AW'(point_index_i);
      sample_q <= sample_value_i;
      rzero_q  <= !(in_grid && slot_ok);
    end
    pa_q[1] <= {slot_q, pt_q};
    pa_q[2] <= pa_q[1];
    pa_q[3] <= pa_q[2];
    pa_q[4] <= pa_q[3];
    if (state_q == ST_READ) begin
      real_sum_q <= rzero_q ? '0 : ram_pair.re;
      imag_sum_q <= rzero_q ? '0 : ram_pair.im;
    end
  end

  rdba_twiddle #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_twiddle (
    .clk_i  (clk_i),
    .phase_i(phase_q[slot_q]),
    .tw_o   (tw)
  );

  rdba_mac u_mac (
    .clk_i   (clk_i),
    .sample_i(sample_q),
    .tw_i    (tw),
    .acc_i   (ram_pair),
    .acc_o   (mac_sum)
  );

  assign ram_pair  = acc_pair_t'(ram_rdata);
  assign ram_we    = (state_q == ST_CLEAR) || pv_q[4];
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : pa_q[4];
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : ACC_PAIR_W'(mac_sum);
  assign ram_raddr = pv_q[3] ? pa_q[3] : {SLOT_AW'(freq_slot_i), PT_AW'(point_index_i)};

  rdba_ram #(
    .WIDTH(ACC_PAIR_W),
    .DEPTH(DEPTH)
  ) u_accum_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign valid_o    = valid_q;
  assign real_sum_o = real_sum_q;
  assign imag_sum_o = imag_sum_q;

`ifndef SYNTHESIS
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((state_q == ST_CLEAR) && pv_q[4]))
    else $error("pipeline write beat during clear sweep");

  a_valid_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_READ))
    else $error("result strobe without a read");

  a_issue_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q[1] |-> $past(state_q == ST_ISSUE))
    else $error("slot entered pipeline outside issue");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> (CW'(slot_q) < CW'(act)))
    else $error("issue slot beyond active count");
`endif

endmodule
